// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Depends on nothing; each macro takes a clock, a reset and a label.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/tbru_pkg.sv -----
// Shared types and codes of the Thumb branch resolve unit.
// Used by tbru_state, tbru_resolve and the top level; depends on nothing.
package tbru_pkg;

  localparam int InWidth  = 168;
  localparam int OutWidth = 144;

  localparam logic [3:0] CMD_B     = 4'd0;
  localparam logic [3:0] CMD_BL    = 4'd1;
  localparam logic [3:0] CMD_BX    = 4'd2;
  localparam logic [3:0] CMD_BLX   = 4'd3;
  localparam logic [3:0] CMD_CBZ   = 4'd4;
  localparam logic [3:0] CMD_CBNZ  = 4'd5;
  localparam logic [3:0] CMD_TBB   = 4'd6;
  localparam logic [3:0] CMD_TBH   = 4'd7;
  localparam logic [3:0] CMD_SG    = 4'd8;
  localparam logic [3:0] CMD_BXNS  = 4'd9;
  localparam logic [3:0] CMD_BLXNS = 4'd10;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_USAGE  = 3'd1;
  localparam logic [2:0] ST_BUS    = 3'd2;
  localparam logic [2:0] ST_SECURE = 3'd3;
  localparam logic [2:0] ST_UNDEF  = 3'd4;
  localparam logic [2:0] ST_EXCRET = 3'd5;

  localparam logic [1:0] MACC_NONE  = 2'd0;
  localparam logic [1:0] MACC_READ  = 2'd1;
  localparam logic [1:0] MACC_WRITE = 2'd2;

  localparam logic [1:0] MSZ_BYTE = 2'd0;
  localparam logic [1:0] MSZ_HALF = 2'd1;
  localparam logic [1:0] MSZ_WORD = 2'd2;

  localparam logic [1:0] ATTR_SECURE = 2'd0;
  localparam logic [1:0] ATTR_NSC    = 2'd1;

  localparam logic       REG_TZ_PRESENT = 1'b0;
  localparam logic       REG_SSP_INIT   = 1'b1;

  localparam logic [31:0] FN_RET_MAGIC = 32'hFEFF_FFFF;
  localparam logic [7:0]  EXC_RET_TOP  = 8'hFF;

  typedef struct packed {
    logic [3:0]         command;
    logic [31:0]        pc;
    logic [2:0]         insn_size;
    logic signed [24:0] imm_offset;
    logic [31:0]        reg_value;
    logic [31:0]        index_value;
    logic [31:0]        mem_data;
    logic               mem_fault;
    logic [1:0]         region_attribute;
  } tbru_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        pc_write;
    logic [31:0] new_pc;
    logic        lr_write;
    logic [31:0] lr_value;
    logic [1:0]  mem_access;
    logic [1:0]  mem_size;
    logic [31:0] mem_addr;
    logic [31:0] mem_write_data;
    logic        clear_caller_saved;
    logic        invstate_flag;
    logic        secure_state;
  } tbru_out_t;

  // Architectural state as seen by the resolve logic.
  typedef struct packed {
    logic        tz_present;
    logic        secure_mode;
    logic [31:0] ssp;
  } tbru_state_t;

  // State update produced by one resolved branch.
  typedef struct packed {
    logic        secure_mode;
    logic [31:0] ssp;
  } tbru_upd_t;

endpackage

// ----- hdl/tbru_state.sv -----
// Security state, secure stack pointer and configuration registers.
// Depends on tbru_pkg.
module tbru_state (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_sel,
  input  logic [31:0]            cfg_wdata,
  input  logic                   upd_en,
  input  tbru_pkg::tbru_upd_t    upd,
  output tbru_pkg::tbru_state_t  state
);

  logic        tz_present;
  logic        secure_mode;
  logic [31:0] ssp;

  always_ff @(posedge clk) begin
    if (rst) begin
      tz_present  <= 1'b0;
      secure_mode <= 1'b1;
      ssp         <= '0;
    end else if (cfg_we) begin
      if (cfg_sel == tbru_pkg::REG_TZ_PRESENT) begin
        tz_present <= cfg_wdata[0];
      end else begin
        ssp <= cfg_wdata;
      end
    end else if (upd_en) begin
      secure_mode <= upd.secure_mode;
      ssp         <= upd.ssp;
    end
  end

  assign state = '{tz_present: tz_present, secure_mode: secure_mode, ssp: ssp};

endmodule

// ----- hdl/tbru_resolve.sv -----
// Combinational resolution of one branch: target, link, memory request,
// status and the state update. Depends on tbru_pkg.
module tbru_resolve (
  input  tbru_pkg::tbru_in_t    item,
  input  tbru_pkg::tbru_state_t state,
  output tbru_pkg::tbru_out_t   res,
  output tbru_pkg::tbru_upd_t   upd
);

  logic [31:0] rel;
  logic [31:0] ret;
  logic [31:0] pc4;
  logic [31:0] tbl_addr;
  logic [15:0] entry;
  logic        exc_ret;
  logic        fnc_ret;
  logic        tgt_chk;

  assign pc4     = item.pc + 32'd4;
  assign rel     = (pc4 + {{7{item.imm_offset[24]}}, item.imm_offset}) & ~32'd1;
  assign ret     = (item.pc + {29'd0, item.insn_size}) | 32'd1;
  assign exc_ret = (item.reg_value[31:24] == tbru_pkg::EXC_RET_TOP);
  assign fnc_ret = (item.reg_value == tbru_pkg::FN_RET_MAGIC);
  assign tbl_addr = (item.command == tbru_pkg::CMD_TBB) ?
                    item.reg_value + item.index_value :
                    item.reg_value + {item.index_value[30:0], 1'b0};
  assign entry   = (item.command == tbru_pkg::CMD_TBB) ?
                   {8'd0, item.mem_data[7:0]} : item.mem_data[15:0];

  always_comb begin
    res             = '0;
    res.status      = tbru_pkg::ST_OK;
    upd.secure_mode = state.secure_mode;
    upd.ssp         = state.ssp;
    tgt_chk         = 1'b0;

    case (item.command)
      tbru_pkg::CMD_B: begin
        res.pc_write = 1'b1;
        res.new_pc   = rel;
      end
      tbru_pkg::CMD_BL: begin
        res.lr_write = 1'b1;
        res.lr_value = ret;
        res.pc_write = 1'b1;
        res.new_pc   = rel;
      end
      tbru_pkg::CMD_BX: begin
        if (exc_ret) begin
          res.status = tbru_pkg::ST_EXCRET;
        end else if (fnc_ret && state.tz_present) begin
          if (state.secure_mode) begin
            res.status        = tbru_pkg::ST_USAGE;
            res.invstate_flag = 1'b1;
          end else begin
            // secure state is entered before the stack pop completes
            upd.secure_mode = 1'b1;
            res.mem_access  = tbru_pkg::MACC_READ;
            res.mem_size    = tbru_pkg::MSZ_WORD;
            res.mem_addr    = state.ssp;
            if (item.mem_fault) begin
              res.status = tbru_pkg::ST_BUS;
            end else begin
              upd.ssp      = state.ssp + 32'd4;
              res.pc_write = 1'b1;
              res.new_pc   = item.mem_data & ~32'd1;
            end
          end
        end else begin
          tgt_chk = 1'b1;
        end
      end
      tbru_pkg::CMD_BLX: begin
        res.lr_write = 1'b1;
        res.lr_value = ret;
        if (exc_ret) begin
          res.status = tbru_pkg::ST_EXCRET;
        end else begin
          tgt_chk = 1'b1;
        end
      end
      tbru_pkg::CMD_CBZ, tbru_pkg::CMD_CBNZ: begin
        if ((item.command == tbru_pkg::CMD_CBZ) == (item.reg_value == 32'd0)) begin
          res.pc_write = 1'b1;
          res.new_pc   = rel;
        end
      end
      tbru_pkg::CMD_TBB, tbru_pkg::CMD_TBH: begin
        res.mem_access = tbru_pkg::MACC_READ;
        res.mem_size   = (item.command == tbru_pkg::CMD_TBB) ?
                         tbru_pkg::MSZ_BYTE : tbru_pkg::MSZ_HALF;
        res.mem_addr   = tbl_addr;
        if (item.mem_fault) begin
          res.status = tbru_pkg::ST_BUS;
        end else begin
          res.pc_write = 1'b1;
          res.new_pc   = (pc4 + {15'd0, entry, 1'b0}) & ~32'd1;
        end
      end
      tbru_pkg::CMD_SG: begin
        if (!state.tz_present) begin
          res.status = tbru_pkg::ST_UNDEF;
        end else if (!state.secure_mode) begin
          if (item.region_attribute != tbru_pkg::ATTR_NSC) begin
            res.status = tbru_pkg::ST_SECURE;
          end else begin
            upd.secure_mode = 1'b1;
          end
        end
      end
      tbru_pkg::CMD_BXNS: begin
        if (!state.tz_present) begin
          res.status = tbru_pkg::ST_UNDEF;
        end else if (state.secure_mode) begin
          if (item.region_attribute == tbru_pkg::ATTR_SECURE) begin
            res.status = tbru_pkg::ST_SECURE;
          end else begin
            res.clear_caller_saved = 1'b1;
            upd.secure_mode        = 1'b0;
            tgt_chk                = 1'b1;
          end
        end else begin
          tgt_chk = 1'b1;
        end
      end
      tbru_pkg::CMD_BLXNS: begin
        if (!state.tz_present) begin
          res.status = tbru_pkg::ST_UNDEF;
        end else begin
          res.lr_write = 1'b1;
          res.lr_value = ret;
          if (state.secure_mode) begin
            if (item.region_attribute == tbru_pkg::ATTR_SECURE) begin
              res.status = tbru_pkg::ST_SECURE;
            end else begin
              // push of the return address to the secure stack
              res.mem_access     = tbru_pkg::MACC_WRITE;
              res.mem_size       = tbru_pkg::MSZ_WORD;
              res.mem_addr       = state.ssp - 32'd4;
              res.mem_write_data = ret;
              if (item.mem_fault) begin
                res.status = tbru_pkg::ST_BUS;
              end else begin
                upd.ssp                = state.ssp - 32'd4;
                res.lr_value           = tbru_pkg::FN_RET_MAGIC;
                res.clear_caller_saved = 1'b1;
                upd.secure_mode        = 1'b0;
                tgt_chk                = 1'b1;
              end
            end
          end else begin
            tgt_chk = 1'b1;
          end
        end
      end
      default: begin
        res.status = tbru_pkg::ST_UNDEF;
      end
    endcase

    // Thumb bit check on a register target
    if (tgt_chk) begin
      if (!item.reg_value[0]) begin
        res.status = tbru_pkg::ST_USAGE;
      end else begin
        res.pc_write = 1'b1;
        res.new_pc   = item.reg_value & ~32'd1;
      end
    end

    res.secure_state = upd.secure_mode;
  end

endmodule

// ----- hdl/thumb_branch_resolve_unit_core.sv -----
// Top level of the Thumb branch resolve unit: input register, resolve
// logic, result register. Depends on tbru_pkg, tbru_state, tbru_resolve.
//
// Usage:
//   s_axis carries one branch instruction per transaction (command, pc,
//   size, offset, register values, memory data/fault, region attribute).
//   m_axis returns one result per branch: status, new PC and LR with write
//   flags, the memory request, clear/INVSTATE flags and the security state.
//   cfg_* writes a register: index 0 enables TrustZone handling, index 1
//   loads the secure stack pointer. Write only while the unit is empty.
// Pipeline: the input register loads on the transaction edge, the result
//   register when the branch advances out of the input register.
// Throughput: one branch per cycle unless the result stalls; the security
//   state and secure stack pointer update in the cycle a branch moves into
//   the result register, so the next branch sees them without a gap.
// Reset: both stages empty, TrustZone disabled, secure state, stack pointer
//   zero.
// Stall: when m_axis_tready is low the result holds; one more branch can
//   sit in the input register, after which s_axis_tready drops.
module thumb_branch_resolve_unit_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[3:0] pc[35:4] insn_size[38:36] imm_offset[63:39]
  // reg_value[95:64] index_value[127:96] mem_data[159:128] mem_fault[160]
  // region_attribute[162:161], zero pad to 167
  input  logic [167:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0] pc_write[3] new_pc[35:4] lr_write[36] lr_value[68:37]
  // mem_access[70:69] mem_size[72:71] mem_addr[104:73]
  // mem_write_data[136:105] clear_caller_saved[137] invstate_flag[138]
  // secure_state[139], zero pad to 143
  output logic [143:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  logic                  in_valid;
  tbru_pkg::tbru_in_t    in_item;
  logic                  out_valid;
  logic [143:0]          out_data;
  logic                  advance;
  tbru_pkg::tbru_out_t   res;
  tbru_pkg::tbru_upd_t   upd;
  tbru_pkg::tbru_state_t state;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.command          <= s_axis_tdata[3:0];
      in_item.pc               <= s_axis_tdata[35:4];
      in_item.insn_size        <= s_axis_tdata[38:36];
      in_item.imm_offset       <= s_axis_tdata[63:39];
      in_item.reg_value        <= s_axis_tdata[95:64];
      in_item.index_value      <= s_axis_tdata[127:96];
      in_item.mem_data         <= s_axis_tdata[159:128];
      in_item.mem_fault        <= s_axis_tdata[160];
      in_item.region_attribute <= s_axis_tdata[162:161];
    end
  end

  tbru_state u_state (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_sel   (cfg_index),
    .cfg_wdata (cfg_data),
    .upd_en    (advance),
    .upd       (upd),
    .state     (state)
  );

  tbru_resolve u_resolve (
    .item  (in_item),
    .state (state),
    .res   (res),
    .upd   (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {4'd0, res.secure_state, res.invstate_flag,
                   res.clear_caller_saved, res.mem_write_data, res.mem_addr,
                   res.mem_size, res.mem_access, res.lr_value, res.lr_write,
                   res.new_pc, res.pc_write, res.status};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// ----- hdl/tbru_checker.sv -----
// Port-level checker for the Thumb branch resolve unit, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tbru_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata
);

  logic out_stall;

  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // a stalled result must not change
  `ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
  // new_pc is zero without pc_write and always halfword aligned
  `ASSERT_IMPL(a_pc_idle, clk, rst, m_axis_tvalid && !m_axis_tdata[3], m_axis_tdata[35:4] == '0)
  `ASSERT_IMPL(a_pc_align, clk, rst, m_axis_tvalid, !m_axis_tdata[4])
  // a link value is a Thumb return address or the function-return magic, both odd
  `ASSERT_IMPL(a_lr_odd, clk, rst, m_axis_tvalid && m_axis_tdata[36], m_axis_tdata[37])

endmodule

bind thumb_branch_resolve_unit_core tbru_checker u_tbru_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- test/tbru_result_checker.sv -----
// Result checker for the Thumb branch resolve unit: watches the branch,
// result and register-write channels, predicts every result and compares it.
// Depends on tbru_pkg.
module tbru_result_checker
  import tbru_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_valid,
  input  logic         s_ready,
  input  logic [167:0] s_data,
  input  logic         m_valid,
  input  logic         m_ready,
  input  logic [143:0] m_data,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  output int           errors,
  output int           checked,
  output int           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        tz_en;
  logic        sec_mode;
  logic [31:0] sec_sp;
  tbru_out_t   resolved_q[$];

  // Interworking target check shared by BX, BLX, BXNS and BLXNS.
  function automatic tbru_out_t take_target(tbru_out_t r, logic [31:0] target);
    if (!target[0]) begin
      r.status = ST_USAGE;
    end else begin
      r.pc_write = 1'b1;
      r.new_pc   = target & ~32'd1;
    end
    return r;
  endfunction

  // Resolves one branch and updates the security state and stack pointer.
  function automatic tbru_out_t resolve_branch(tbru_in_t b);
    tbru_out_t   r;
    logic [31:0] rel, ret, entry, nsp, off32;
    r      = '0;
    off32  = {{7{b.imm_offset[24]}}, b.imm_offset};
    rel    = (b.pc + 32'd4 + off32) & ~32'd1;
    ret    = (b.pc + {29'd0, b.insn_size}) | 32'd1;
    r.status = ST_OK;
    case (b.command)
      CMD_B: begin
        r.pc_write = 1'b1;
        r.new_pc   = rel;
      end
      CMD_BL: begin
        r.lr_write = 1'b1;
        r.lr_value = ret;
        r.pc_write = 1'b1;
        r.new_pc   = rel;
      end
      CMD_BX: begin
        if (b.reg_value[31:24] == EXC_RET_TOP) begin
          r.status = ST_EXCRET;
        end else if (b.reg_value == FN_RET_MAGIC && tz_en) begin
          if (sec_mode) begin
            r.status        = ST_USAGE;
            r.invstate_flag = 1'b1;
          end else begin
            // secure state is entered before the pop, even if it faults
            sec_mode     = 1'b1;
            r.mem_access = MACC_READ;
            r.mem_size   = MSZ_WORD;
            r.mem_addr   = sec_sp;
            if (b.mem_fault) begin
              r.status = ST_BUS;
            end else begin
              sec_sp     = sec_sp + 32'd4;
              r.pc_write = 1'b1;
              r.new_pc   = b.mem_data & ~32'd1;
            end
          end
        end else begin
          r = take_target(r, b.reg_value);
        end
      end
      CMD_BLX: begin
        r.lr_write = 1'b1;
        r.lr_value = ret;
        if (b.reg_value[31:24] == EXC_RET_TOP) r.status = ST_EXCRET;
        else r = take_target(r, b.reg_value);
      end
      CMD_CBZ, CMD_CBNZ: begin
        if ((b.command == CMD_CBZ) == (b.reg_value == 32'd0)) begin
          r.pc_write = 1'b1;
          r.new_pc   = rel;
        end
      end
      CMD_TBB, CMD_TBH: begin
        r.mem_access = MACC_READ;
        if (b.command == CMD_TBB) begin
          r.mem_size = MSZ_BYTE;
          r.mem_addr = b.reg_value + b.index_value;
          entry      = {24'd0, b.mem_data[7:0]};
        end else begin
          r.mem_size = MSZ_HALF;
          r.mem_addr = b.reg_value + (b.index_value << 1);
          entry      = {16'd0, b.mem_data[15:0]};
        end
        if (b.mem_fault) begin
          r.status = ST_BUS;
        end else begin
          r.pc_write = 1'b1;
          r.new_pc   = (b.pc + 32'd4 + (entry << 1)) & ~32'd1;
        end
      end
      CMD_SG: begin
        if (!tz_en) r.status = ST_UNDEF;
        else if (!sec_mode) begin
          if (b.region_attribute != ATTR_NSC) r.status = ST_SECURE;
          else sec_mode = 1'b1;
        end
      end
      CMD_BXNS: begin
        if (!tz_en) begin
          r.status = ST_UNDEF;
        end else if (sec_mode && b.region_attribute == ATTR_SECURE) begin
          r.status = ST_SECURE;
        end else begin
          if (sec_mode) begin
            r.clear_caller_saved = 1'b1;
            sec_mode             = 1'b0;
          end
          r = take_target(r, b.reg_value);
        end
      end
      CMD_BLXNS: begin
        if (!tz_en) begin
          r.status = ST_UNDEF;
        end else begin
          r.lr_write = 1'b1;
          r.lr_value = ret;
          if (!sec_mode) begin
            r = take_target(r, b.reg_value);
          end else if (b.region_attribute == ATTR_SECURE) begin
            r.status = ST_SECURE;
          end else begin
            nsp              = sec_sp - 32'd4;
            r.mem_access     = MACC_WRITE;
            r.mem_size       = MSZ_WORD;
            r.mem_addr       = nsp;
            r.mem_write_data = ret;
            if (b.mem_fault) begin
              r.status = ST_BUS;
            end else begin
              sec_sp               = nsp;
              r.lr_value           = FN_RET_MAGIC;
              r.clear_caller_saved = 1'b1;
              sec_mode             = 1'b0;
              r = take_target(r, b.reg_value);
            end
          end
        end
      end
      default: r.status = ST_UNDEF;
    endcase
    r.secure_state = sec_mode;
    return r;
  endfunction

  function automatic tbru_in_t unpack_branch(logic [167:0] d);
    tbru_in_t b;
    b.command          = d[3:0];
    b.pc               = d[35:4];
    b.insn_size        = d[38:36];
    b.imm_offset       = d[63:39];
    b.reg_value        = d[95:64];
    b.index_value      = d[127:96];
    b.mem_data         = d[159:128];
    b.mem_fault        = d[160];
    b.region_attribute = d[162:161];
    return b;
  endfunction

  function automatic tbru_out_t unpack_result(logic [143:0] d);
    tbru_out_t r;
    r.status             = d[2:0];
    r.pc_write           = d[3];
    r.new_pc             = d[35:4];
    r.lr_write           = d[36];
    r.lr_value           = d[68:37];
    r.mem_access         = d[70:69];
    r.mem_size           = d[72:71];
    r.mem_addr           = d[104:73];
    r.mem_write_data     = d[136:105];
    r.clear_caller_saved = d[137];
    r.invstate_flag      = d[138];
    r.secure_state       = d[139];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : watch
    tbru_out_t want, got;
    if (rst) begin
      tz_en    = 1'b0;
      sec_mode = 1'b1;
      sec_sp   = '0;
      resolved_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TZ_PRESENT) tz_en = cfg_data[0];
        else sec_sp = cfg_data;
      end
      // compare before pushing: a result never belongs to a branch taken this cycle
      if (m_valid && m_ready) begin
        got = unpack_result(m_data);
        if (resolved_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, m_data);
        end else begin
          want = resolved_q.pop_front();
          checked++;
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("pc_write", 32'(want.pc_write), 32'(got.pc_write));
          check_field("new_pc", want.new_pc, got.new_pc);
          check_field("lr_write", 32'(want.lr_write), 32'(got.lr_write));
          check_field("lr_value", want.lr_value, got.lr_value);
          check_field("mem_access", 32'(want.mem_access), 32'(got.mem_access));
          check_field("mem_size", 32'(want.mem_size), 32'(got.mem_size));
          check_field("mem_addr", want.mem_addr, got.mem_addr);
          check_field("mem_write_data", want.mem_write_data, got.mem_write_data);
          check_field("clear_caller_saved", 32'(want.clear_caller_saved),
                      32'(got.clear_caller_saved));
          check_field("invstate_flag", 32'(want.invstate_flag), 32'(got.invstate_flag));
          check_field("secure_state", 32'(want.secure_state), 32'(got.secure_state));
        end
      end
      if (s_valid && s_ready) resolved_q.push_back(resolve_branch(unpack_branch(s_data)));
      outstanding <= resolved_q.size();
    end
  end

endmodule

// ----- test/tb_thumb_branch_resolve_unit_core.sv -----
// Testbench top for thumb_branch_resolve_unit_core: clock, reset, branch and
// register-write stimulus, result backpressure and the verdict.
// Depends on tbru_pkg, the core and tbru_result_checker.
module tb_thumb_branch_resolve_unit_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tbru_pkg::*;

  localparam logic [1:0] ATTR_NONSEC = 2'd2;
  localparam logic [1:0] ATTR_RSVD   = 2'd3;
  localparam logic [3:0] CMD_BAD_LO  = 4'd11;
  localparam logic [3:0] CMD_BAD_HI  = 4'd15;
  localparam int         RAND_PHASES = 5;
  localparam int         PHASE_ITEMS = 140;
  localparam int         HOLD_CYCLES = 64;
  localparam int         CYCLE_LIMIT = 200000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = REG_TZ_PRESENT;
  logic [31:0]  cfg_data = '0;

  int   errors, checked, outstanding;
  int   cycles = 0;
  int   sent = 0;
  int   settings = 0;
  bit   idle_on = 1'b1;
  bit   hold_req = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  thumb_branch_resolve_unit_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  tbru_result_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_valid     (s_axis_tvalid),
    .s_ready     (s_axis_tready),
    .s_data      (s_axis_tdata),
    .m_valid     (m_axis_tvalid),
    .m_ready     (m_axis_tready),
    .m_data      (m_axis_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .checked     (checked),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("simulation failed");
      $finish;
    end
  end

  // Result sink: random backpressure, plus one long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done     <= 1'b1;
      hold_left     <= HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !idle_on || ($urandom_range(99) >= 24);
    end
  end

  task automatic send_branch(input logic [3:0] cmd, input logic [31:0] pc,
                             input logic [2:0] size, input logic [24:0] off,
                             input logic [31:0] rv, input logic [31:0] idx,
                             input logic [31:0] md, input logic mf, input logic [1:0] attr);
    if (idle_on && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, attr, mf, md, idx, rv, off, size, pc, cmd};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_regs(input logic tz, input logic [31:0] ssp);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TZ_PRESENT;
    cfg_data  <= {31'd0, tz};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_SSP_INIT;
    cfg_data  <= ssp;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Random branch; with TrustZone on, security transitions dominate.
  task automatic send_random(input bit tz_heavy);
    logic [3:0]  cmd;
    logic [31:0] rv, idx;
    logic [24:0] off;
    logic [2:0]  size;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 3) cmd = 4'($urandom_range(CMD_BAD_HI, CMD_BAD_LO));
    else if (!tz_heavy) cmd = 4'($urandom_range(CMD_BLXNS, CMD_B));
    else if (pick < 18) cmd = CMD_SG;
    else if (pick < 38) cmd = CMD_BLXNS;
    else if (pick < 52) cmd = CMD_BXNS;
    else if (pick < 70) cmd = CMD_BX;
    else cmd = 4'($urandom_range(CMD_TBH, CMD_B));
    case ($urandom_range(9))
      0:       rv = '0;
      1:       rv = FN_RET_MAGIC;
      2:       rv = {EXC_RET_TOP, 24'($urandom)};
      3, 4, 5: rv = $urandom | 32'd1;
      6, 7:    rv = $urandom & ~32'd1;
      default: rv = $urandom;
    endcase
    if (cmd == CMD_BX && tz_heavy && $urandom_range(9) < 6) rv = FN_RET_MAGIC;
    idx  = ($urandom_range(9) < 3) ? 32'($urandom_range(255)) : $urandom;
    off  = ($urandom_range(19) == 0) ? {1'($urandom_range(1)), 24'd0} : 25'($urandom);
    size = ($urandom_range(9) < 8) ? (($urandom_range(1) != 0) ? 3'd4 : 3'd2)
                                   : 3'($urandom);
    send_branch(cmd, $urandom, size, off, rv, idx, $urandom,
                $urandom_range(99) < 15, 2'($urandom));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: TrustZone off, stack pointer zero.
    send_branch(CMD_B, 32'h0, 3'd2, 25'h0FF_FFFE, '0, '0, '0, 1'b0, ATTR_SECURE);
    send_branch(CMD_B, 32'hFFFF_FFFF, 3'd4, 25'h100_0000, '0, '0, '0, 1'b0, ATTR_SECURE);
    send_branch(CMD_BL, 32'h0000_1000, 3'd7, 25'h1FF_FFFE, '0, '0, '0, 1'b1, ATTR_RSVD);
    send_branch(CMD_BX, 32'h100, 3'd2, '0, 32'h0000_2000, '0, '0, 1'b0, ATTR_SECURE);
    send_branch(CMD_BX, 32'h100, 3'd2, '0, FN_RET_MAGIC, '0, '0, 1'b0, ATTR_NONSEC);
    send_branch(CMD_BLX, 32'h200, 3'd0, '0, 32'hFF00_0000, '0, '0, 1'b0, ATTR_SECURE);
    send_branch(CMD_CBZ, 32'h300, 3'd2, 25'h7E, '0, '0, '0, 1'b0, ATTR_SECURE);
    send_branch(CMD_CBNZ, 32'h300, 3'd2, 25'h7E, 32'hFFFF_FFFF, '0, '0, 1'b0, ATTR_SECURE);
    send_branch(CMD_TBB, 32'h400, 3'd4, '0, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 1'b0,
                ATTR_SECURE);
    send_branch(CMD_TBH, 32'h400, 3'd4, '0, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF, 1'b1,
                ATTR_SECURE);
    send_branch(CMD_SG, 32'h500, 3'd4, '0, '0, '0, '0, 1'b0, ATTR_NSC);
    send_branch(CMD_BLXNS, 32'h500, 3'd2, '0, 32'h1, '0, '0, 1'b0, ATTR_NSC);
    send_branch(CMD_BAD_HI, 32'h600, 3'd2, '0, '0, '0, '0, 1'b0, ATTR_SECURE);
    drain_results();

    // Security extension transitions, starting in secure state.
    write_regs(1'b1, 32'h2000_0400);
    send_branch(CMD_SG, 32'h700, 3'd4, '0, '0, '0, '0, 1'b0, ATTR_NONSEC);
    send_branch(CMD_BX, 32'h704, 3'd2, '0, FN_RET_MAGIC, '0, '0, 1'b0, ATTR_SECURE);
    send_branch(CMD_BXNS, 32'h706, 3'd2, '0, 32'h801, '0, '0, 1'b0, ATTR_SECURE);
    send_branch(CMD_BLXNS, 32'h708, 3'd2, '0, 32'h901, '0, '0, 1'b1, ATTR_NONSEC);
    send_branch(CMD_BLXNS, 32'h70A, 3'd2, '0, 32'h900, '0, '0, 1'b0, ATTR_NSC);
    send_branch(CMD_SG, 32'h900, 3'd4, '0, '0, '0, '0, 1'b0, ATTR_NONSEC);
    send_branch(CMD_SG, 32'h900, 3'd4, '0, '0, '0, '0, 1'b0, ATTR_NSC);
    send_branch(CMD_BXNS, 32'h904, 3'd2, '0, 32'hA01, '0, '0, 1'b0, ATTR_RSVD);
    send_branch(CMD_BLXNS, 32'hA00, 3'd2, '0, 32'hB01, '0, '0, 1'b0, ATTR_SECURE);
    send_branch(CMD_BX, 32'hB00, 3'd2, '0, FN_RET_MAGIC, '0, 32'h1234_5679, 1'b1, ATTR_SECURE);
    send_branch(CMD_BXNS, 32'hB02, 3'd2, '0, 32'hC01, '0, '0, 1'b0, ATTR_NONSEC);
    send_branch(CMD_BXNS, 32'hC00, 3'd2, '0, 32'hC10, '0, '0, 1'b0, ATTR_NONSEC);
    send_branch(CMD_BX, 32'hC02, 3'd2, '0, FN_RET_MAGIC, '0, 32'h1234_5679, 1'b0, ATTR_SECURE);
    drain_results();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       write_regs(1'b1, 32'h0);
        1:       write_regs(1'b0, 32'hFFFF_FFFF);
        2:       write_regs(1'b1, 32'hFFFF_FFFF);
        3:       write_regs(1'b1, $urandom);
        default: write_regs(1'b0, $urandom);
      endcase
      idle_on  = (ph != 2);
      hold_req = (ph == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == PHASE_ITEMS / 2) drain_results();
        send_random(ph != 1 && ph != 4);
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    $display("%0d branches sent over %0d register settings, %0d results checked, %0d errors",
             sent, settings, checked, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
